### rtl/ycc_pkg.sv
`default_nettype none

package ycc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = FRAC_BITS + 2;
  localparam int ACC_W     = FRAC_BITS + 12;
  localparam int GPROD_W   = COEF_W + 8;
  localparam int GSUM_W    = GPROD_W + 2;

  localparam longint unsigned Half5  = 64'd50000;
  localparam longint unsigned Scale5 = 64'd100000;

  localparam logic [COEF_W-1:0] K_CR_R =
    COEF_W'(((64'd140200 << FRAC_BITS) + Half5) / Scale5);
  localparam logic [COEF_W-1:0] K_CB_G =
    COEF_W'(((64'd34414 << FRAC_BITS) + Half5) / Scale5);
  localparam logic [COEF_W-1:0] K_CR_G =
    COEF_W'(((64'd71414 << FRAC_BITS) + Half5) / Scale5);
  localparam logic [COEF_W-1:0] K_CB_B =
    COEF_W'(((64'd177200 << FRAC_BITS) + Half5) / Scale5);
  localparam logic [COEF_W-1:0] K_GRAY_R =
    COEF_W'(((64'd21260 << FRAC_BITS) + Half5) / Scale5);
  localparam logic [COEF_W-1:0] K_GRAY_G =
    COEF_W'(((64'd71520 << FRAC_BITS) + Half5) / Scale5);
  localparam logic [COEF_W-1:0] K_GRAY_B =
    COEF_W'(((64'd7220 << FRAC_BITS) + Half5) / Scale5);

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [7:0] luma_in;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } ycc_pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] gray_out;
  } ycc_result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ycc_rgb_t;

  typedef struct packed {
    logic prod_en;
    logic clamp_en;
  } ycc_matrix_en_t;

endpackage

`default_nettype wire

### rtl/ycc_color_matrix.sv
`default_nettype none

module ycc_color_matrix (
  input  wire logic                    clk,
  input  wire ycc_pkg::ycc_matrix_en_t en,
  input  wire ycc_pkg::ycc_pixel_t     pixel,
  output ycc_pkg::ycc_rgb_t            rgb
);
  import ycc_pkg::*;

  function automatic logic [7:0] clamp_channel(input acc_t acc);
    logic [7:0] v;
    if (acc[ACC_W-1]) begin
      v = 8'd0;
    end else if (|acc[ACC_W-2:FRAC_BITS+8]) begin
      v = 8'd255;
    end else begin
      v = acc[FRAC_BITS+7:FRAC_BITS];
    end
    return v;
  endfunction

  logic signed [7:0] cb_s;
  logic signed [7:0] cr_s;
  acc_t ybase_r, p_cr_r_r, p_cb_g_r, p_cr_g_r, p_cb_b_r;
  acc_t acc_r, acc_g, acc_b;
  ycc_rgb_t rgb_r;

  // offset binary minus 128 is the msb flipped
  assign cb_s = $signed({~pixel.chroma_blue[7], pixel.chroma_blue[6:0]});
  assign cr_s = $signed({~pixel.chroma_red[7], pixel.chroma_red[6:0]});

  always_ff @(posedge clk) begin
    if (en.prod_en) begin
      ybase_r  <= acc_t'({4'b0000, pixel.luma_in, {FRAC_BITS{1'b0}}});
      p_cr_r_r <= acc_t'({1'b0, K_CR_R}) * acc_t'(cr_s);
      p_cb_g_r <= acc_t'({1'b0, K_CB_G}) * acc_t'(cb_s);
      p_cr_g_r <= acc_t'({1'b0, K_CR_G}) * acc_t'(cr_s);
      p_cb_b_r <= acc_t'({1'b0, K_CB_B}) * acc_t'(cb_s);
    end
  end

  assign acc_r = ybase_r + p_cr_r_r;
  assign acc_g = ybase_r - p_cb_g_r - p_cr_g_r;
  assign acc_b = ybase_r + p_cb_b_r;

  always_ff @(posedge clk) begin
    if (en.clamp_en) begin
      rgb_r.red   <= clamp_channel(acc_r);
      rgb_r.green <= clamp_channel(acc_g);
      rgb_r.blue  <= clamp_channel(acc_b);
    end
  end

  assign rgb = rgb_r;

endmodule

`default_nettype wire

### rtl/ycbcr_to_rgb_gray_converter.sv
// Full-range YCbCr pixel to RGB plus gray value.
// Input channel: in_valid / in_stall carry one pixel beat in in_pixel
// (luma, chroma blue, chroma red, one byte each). A beat is taken at a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result beat in out_result
// (red, green, blue clamped to 0..255, and a weighted gray value).
// Every input beat gives exactly one output beat, in order.
// From input beat to out_valid a beat passes these register stages in order:
// coefficient products, channel sum and clamp, gray products, gray sum and
// saturate. Throughput is one pixel per cycle while out_stall is low.
// When out_stall is high the last stage holds its beat unchanged; earlier
// stages keep filling their empty slots, and in_stall rises only once every
// stage holds a beat.
// Reset (rst_n low, synchronous) empties all stages; out_valid drops on the
// next edge and no beat is lost or repeated after the stall is released.
`default_nettype none

module ycbcr_to_rgb_gray_converter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ycc_pkg::ycc_pixel_t  in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ycc_pkg::ycc_result_t      out_result
);
  import ycc_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  ycc_matrix_en_t mat_en;
  ycc_rgb_t rgb;
  ycc_rgb_t rgb3_r;
  logic [GPROD_W-1:0] gp_r_r, gp_g_r, gp_b_r;
  logic [GSUM_W-1:0] gsum;
  logic [7:0] gray;
  ycc_result_t result_r;

  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign mat_en.prod_en  = rdy1;
  assign mat_en.clamp_en = rdy2;

  ycc_color_matrix u_matrix (
    .clk   (clk),
    .en    (mat_en),
    .pixel (in_pixel),
    .rgb   (rgb)
  );

  always_ff @(posedge clk) begin
    if (rdy3) begin
      rgb3_r <= rgb;
      gp_r_r <= GPROD_W'(K_GRAY_R) * GPROD_W'(rgb.red);
      gp_g_r <= GPROD_W'(K_GRAY_G) * GPROD_W'(rgb.green);
      gp_b_r <= GPROD_W'(K_GRAY_B) * GPROD_W'(rgb.blue);
    end
  end

  assign gsum = GSUM_W'(gp_r_r) + GSUM_W'(gp_g_r) + GSUM_W'(gp_b_r);
  assign gray = (|gsum[GSUM_W-1:FRAC_BITS+8]) ? 8'd255 : gsum[FRAC_BITS+7:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      result_r.red_out   <= rgb3_r.red;
      result_r.green_out <= rgb3_r.green;
      result_r.blue_out  <= rgb3_r.blue;
      result_r.gray_out  <= gray;
    end
  end

  assign out_valid  = v4_r;
  assign out_result = result_r;

endmodule

`default_nettype wire
